// ----- rtl/ookpe_pkg.sv -----
// Shared types and constants for the OOK remote code pulse encoder.
package ookpe_pkg;

    localparam int unsigned CODE_W  = 24;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned REP_W   = 4;
    localparam int unsigned UNIT_W  = 5;

    localparam logic [POS_W-1:0]  TOP_BIT = POS_W'(CODE_W - 1);
    localparam logic [REP_W-1:0]  REPS_RESET = 4'd4;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // pulse part lengths in base units
    localparam logic [UNIT_W-1:0] SHORT_SYNC_HI = 5'd1;
    localparam logic [UNIT_W-1:0] SHORT_SYNC_LO = 5'd6;
    localparam logic [UNIT_W-1:0] LONG_SYNC_HI  = 5'd8;
    localparam logic [UNIT_W-1:0] LONG_SYNC_LO  = 5'd19;
    localparam logic [UNIT_W-1:0] BIT_LONG      = 5'd3;
    localparam logic [UNIT_W-1:0] BIT_SHORT     = 5'd1;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_last;
        logic start_ignored;
    } t_result;

endpackage

// ----- rtl/ookpe_core.sv -----
// Frame sequencer state and per-word step logic for the OOK encoder.
module ookpe_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_cmd,
    input  logic [ookpe_pkg::CODE_W-1:0]  i_code_word,
    input  logic [ookpe_pkg::REP_W-1:0]   i_repetitions,
    output ookpe_pkg::t_result            o_res
);
    import ookpe_pkg::*;

    logic [CODE_W-1:0] r_shift_code, n_shift_code;
    logic [POS_W-1:0]  r_bit_position, n_bit_position;
    logic [REP_W-1:0]  r_repeat_count, n_repeat_count;
    logic              r_long_sync_round, n_long_sync_round;
    logic              r_in_sync_phase, n_in_sync_phase;
    logic              r_in_low_part, n_in_low_part;
    logic [UNIT_W-1:0] r_unit_count, n_unit_count;
    logic              r_active, n_active;

    logic [CODE_W-1:0] shifted;
    logic              code_bit;
    logic [UNIT_W-1:0] part_len;
    logic [UNIT_W-1:0] unit_inc;
    logic [REP_W-1:0]  repeat_inc;
    t_result           res;

    always_comb begin
        shifted  = r_shift_code >> r_bit_position;
        code_bit = (r_bit_position > TOP_BIT) ? 1'b0 : shifted[0];
        if (r_in_sync_phase) begin
            if (r_long_sync_round) begin
                part_len = r_in_low_part ? LONG_SYNC_LO : LONG_SYNC_HI;
            end else begin
                part_len = r_in_low_part ? SHORT_SYNC_LO : SHORT_SYNC_HI;
            end
        end else if (code_bit) begin
            part_len = r_in_low_part ? BIT_SHORT : BIT_LONG;
        end else begin
            part_len = r_in_low_part ? BIT_LONG : BIT_SHORT;
        end
        unit_inc   = r_unit_count + UNIT_W'(1);
        repeat_inc = r_repeat_count + REP_W'(1);
    end

    always_comb begin
        n_shift_code      = r_shift_code;
        n_bit_position    = r_bit_position;
        n_repeat_count    = r_repeat_count;
        n_long_sync_round = r_long_sync_round;
        n_in_sync_phase   = r_in_sync_phase;
        n_in_low_part     = r_in_low_part;
        n_unit_count      = r_unit_count;
        n_active          = r_active;
        res               = '0;

        if (i_cmd == CMD_START) begin
            res.busy_res = 1'b1;
            if (r_active) begin
                res.start_ignored = 1'b1;
            end else begin
                n_shift_code      = i_code_word;
                n_bit_position    = TOP_BIT;
                n_repeat_count    = '0;
                n_long_sync_round = 1'b0;
                n_in_sync_phase   = 1'b1;
                n_in_low_part     = 1'b0;
                n_unit_count      = '0;
                n_active          = 1'b1;
            end
        end else if (r_active) begin
            res.busy_res   = 1'b1;
            res.line_level = ~r_in_low_part;
            n_unit_count   = unit_inc;
            if (unit_inc >= part_len) begin
                n_unit_count = '0;
                if (!r_in_low_part) begin
                    n_in_low_part = 1'b1;
                end else begin
                    n_in_low_part = 1'b0;
                    if (r_in_sync_phase) begin
                        n_in_sync_phase = 1'b0;
                        n_bit_position  = TOP_BIT;
                    end else if (r_bit_position == '0 || r_bit_position > TOP_BIT) begin
                        n_repeat_count  = repeat_inc;
                        n_in_sync_phase = 1'b1;
                        n_bit_position  = TOP_BIT;
                        if (repeat_inc == i_repetitions) begin
                            n_repeat_count = '0;
                            if (r_long_sync_round) begin
                                n_long_sync_round = 1'b0;
                                n_in_sync_phase   = 1'b0;
                                n_active          = 1'b0;
                                res.frame_last    = 1'b1;
                            end else begin
                                n_long_sync_round = 1'b1;
                            end
                        end
                    end else begin
                        n_bit_position = r_bit_position - POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_code      <= '0;
            r_bit_position    <= '0;
            r_repeat_count    <= '0;
            r_long_sync_round <= 1'b0;
            r_in_sync_phase   <= 1'b0;
            r_in_low_part     <= 1'b0;
            r_unit_count      <= '0;
            r_active          <= 1'b0;
        end else if (i_step) begin
            r_shift_code      <= n_shift_code;
            r_bit_position    <= n_bit_position;
            r_repeat_count    <= n_repeat_count;
            r_long_sync_round <= n_long_sync_round;
            r_in_sync_phase   <= n_in_sync_phase;
            r_in_low_part     <= n_in_low_part;
            r_unit_count      <= n_unit_count;
            r_active          <= n_active;
        end
    end

    assign o_res = res;

endmodule

// ----- rtl/ook_remote_code_pulse_encoder.sv -----
// Top level of the OOK remote code pulse encoder: input word register, step, result register.
//
//   port group   direction  handshake            payload
//   input word   in         i_valid / o_stall    i_cmd, i_code_word
//   result word  out        o_valid / i_stall    o_line_level, o_busy_res, o_frame_last,
//                                                o_start_ignored
//   config       in         i_cfg_wr_en          i_cfg_wr_data (repetitions)
//
// One word per cycle while o_stall is low; a word's result is registered, and the frame
// state advances, as the word leaves the input register into the result register.
// Synchronous active-low reset empties both registers, idles the sequencer and sets
// repetitions to 4. A stalled result holds the input register; o_stall is high while
// both registers are full and i_stall is high.
module ook_remote_code_pulse_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [ookpe_pkg::CODE_W-1:0]  i_code_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_line_level,
    output logic                          o_busy_res,
    output logic                          o_frame_last,
    output logic                          o_start_ignored,
    input  logic                          i_cfg_wr_en,
    input  logic [ookpe_pkg::REP_W-1:0]   i_cfg_wr_data
);
    import ookpe_pkg::*;

    logic              r_in_valid;
    logic              r_cmd;
    logic [CODE_W-1:0] r_code_word;
    logic              r_out_valid;
    t_result           r_res;
    logic [REP_W-1:0]  r_repetitions;

    logic    out_free;
    logic    step;
    logic    in_take;
    t_result step_res;

    assign out_free = ~r_out_valid | ~i_stall;
    assign step     = r_in_valid & out_free;
    assign o_stall  = r_in_valid & ~out_free;
    assign in_take  = i_valid & ~o_stall;

    ookpe_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_cmd         (r_cmd),
        .i_code_word   (r_code_word),
        .i_repetitions (r_repetitions),
        .o_res         (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_repetitions <= REPS_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_repetitions <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd       <= i_cmd;
            r_code_word <= i_code_word;
        end
        if (step) begin
            r_res <= step_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_line_level    = r_res.line_level;
    assign o_busy_res      = r_res.busy_res;
    assign o_frame_last    = r_res.frame_last;
    assign o_start_ignored = r_res.start_ignored;

endmodule
